// ===== rtl/gst_pkg.sv =====
// ----------------------------------------------------------------------------
// gst_pkg
// Shared types, constants and helpers for the geodesic step and termination
// core.
// ----------------------------------------------------------------------------
`default_nettype none

package gst_pkg;

  localparam int SQRT_STAGES  = 32;
  localparam int QUO_BITS     = 47;
  localparam int DIV_STAGES   = QUO_BITS + 1;
  localparam int FRONT_STAGES = 3 + SQRT_STAGES + 1;
  localparam int BACK_STAGES  = 1 + DIV_STAGES + SQRT_STAGES + 2;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [30:0] SAT_MAX = 31'h7FFF_FFFF;

  localparam logic [2:0] REG_HORIZON  = 3'd0;
  localparam logic [2:0] REG_RAY_TOL  = 3'd1;
  localparam logic [2:0] REG_OBS_TOL  = 3'd2;
  localparam logic [2:0] REG_STALL    = 3'd3;
  localparam logic [2:0] REG_INNER    = 3'd4;
  localparam logic [2:0] REG_OUTER    = 3'd5;
  localparam logic [2:0] REG_STEP_LIM = 3'd6;

  typedef enum logic [2:0] {
    REASON_NONE     = 3'd0,
    REASON_CAPTURED = 3'd1,
    REASON_STEPS    = 3'd2,
    REASON_ESCAPED  = 3'd3,
    REASON_RANGE    = 3'd4
  } reason_t;

  typedef struct packed {
    logic [30:0] horizon_radius;
    logic [30:0] ray_tolerance;
    logic [30:0] observer_tolerance;
    logic [30:0] stall_threshold;
    logic [30:0] inner_limit;
    logic [30:0] outer_limit;
    logic [15:0] step_limit;
  } cfg_t;

  typedef struct packed {
    logic        mode;
    reason_t     reason;
    logic [31:0] r;
    logic [31:0] v;
    logic [31:0] a;
    logic [31:0] vt;
  } q_entry_t;

  function automatic logic [31:0] mag32(input logic [31:0] x);
    return x[31] ? (~x + 32'd1) : x;
  endfunction

  function automatic logic [30:0] sat31(input logic [QUO_BITS-1:0] q);
    return (|q[QUO_BITS-1:31]) ? SAT_MAX : q[30:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/gst_item_if.sv =====
// ----------------------------------------------------------------------------
// gst_item_if
// Request channel carrying one ray or observer state.
// ----------------------------------------------------------------------------
`default_nettype none

interface gst_item_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] vel_t;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] vel_z;
  logic signed [31:0] acc_x;
  logic signed [31:0] acc_y;
  logic signed [31:0] acc_z;
  logic        [15:0] step_count;

  modport source (output valid, mode, pos_x, pos_y, pos_z, vel_t, vel_x, vel_y, vel_z,
                  acc_x, acc_y, acc_z, step_count, input ready);
  modport sink   (input valid, mode, pos_x, pos_y, pos_z, vel_t, vel_x, vel_y, vel_z,
                  acc_x, acc_y, acc_z, step_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/gst_result_if.sv =====
// ----------------------------------------------------------------------------
// gst_result_if
// Result channel: step size and termination code.
// ----------------------------------------------------------------------------
`default_nettype none

interface gst_result_if;
  logic        valid;
  logic        ready;
  logic [30:0] step_size;
  logic        finished;
  logic [2:0]  end_reason;

  modport source (output valid, step_size, finished, end_reason, input ready);
  modport sink   (input valid, step_size, finished, end_reason, output ready);
endinterface

`default_nettype wire

// ===== rtl/geodesic_step_and_termination_core.sv =====
// ----------------------------------------------------------------------------
// geodesic_step_and_termination_core
// Adaptive step size and termination code for one ray or observer state.
// ----------------------------------------------------------------------------
//   channel   kind                 contents
//   items     valid/ready, sink    mode, position, four-velocity, accel, steps
//   results   valid/ready, source  step_size, finished, end_reason
//   cfg       write only           cfg_we, cfg_index, cfg_data
//
// One request per cycle sustained while neither part stalls; the pipeline
// depth is set by the one-bit-per-stage square roots and dividers.
// Synchronous reset clears valid bits and queue pointers and loads the configuration registers with defaults.
// The front stalls only on a full queue, the back only on results.ready.
// ----------------------------------------------------------------------------
`default_nettype none

module geodesic_step_and_termination_core import gst_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [30:0]   cfg_data,
  gst_item_if.sink      items,
  gst_result_if.source  results
);

  cfg_t     cfg;
  logic     push_valid, push_ready, pop_valid, pop_ready;
  q_entry_t push_data, pop_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.horizon_radius     <= 31'd65536;
      cfg.ray_tolerance      <= 31'd655;
      cfg.observer_tolerance <= 31'd655;
      cfg.stall_threshold    <= 31'd66;
      cfg.inner_limit        <= 31'd65536;
      cfg.outer_limit        <= 31'd6553600;
      cfg.step_limit         <= 16'd10000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HORIZON:  cfg.horizon_radius     <= cfg_data;
        REG_RAY_TOL:  cfg.ray_tolerance      <= cfg_data;
        REG_OBS_TOL:  cfg.observer_tolerance <= cfg_data;
        REG_STALL:    cfg.stall_threshold    <= cfg_data;
        REG_INNER:    cfg.inner_limit        <= cfg_data;
        REG_OUTER:    cfg.outer_limit        <= cfg_data;
        REG_STEP_LIM: cfg.step_limit         <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  gst_front u_front (
    .clk(clk), .rst(rst), .cfg(cfg), .items(items),
    .push_valid(push_valid), .push_ready(push_ready), .push_data(push_data)
  );

  gst_queue u_queue (
    .clk(clk), .rst(rst),
    .push_valid(push_valid), .push_ready(push_ready), .push_data(push_data),
    .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_data)
  );

  gst_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg),
    .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_data),
    .results(results)
  );

endmodule

`default_nettype wire

// ===== rtl/gst_isqrt.sv =====
// ----------------------------------------------------------------------------
// gst_isqrt
// Pipelined floor square root, 64 bit in, 32 bit out, one root bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module gst_isqrt import gst_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] value,
  output logic [31:0] root
);

  logic [63:0] rem [SQRT_STAGES-1];
  logic [31:0] rt  [SQRT_STAGES];

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
    localparam int B = SQRT_STAGES - 1 - k;
    logic [63:0] rem_in;
    logic [31:0] rt_in;
    logic [65:0] trial;
    logic        take;

    if (k == 0) begin : g_first
      assign rem_in = value;
      assign rt_in  = '0;
    end else begin : g_next
      assign rem_in = rem[k-1];
      assign rt_in  = rt[k-1];
    end

    // candidate squared minus current square: 2*root*2^B + 2^2B
    assign trial = ({34'd0, rt_in} << (B + 1)) | (66'd1 << (2 * B));
    assign take  = {2'b00, rem_in} >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rt[k] <= take ? (rt_in | (32'd1 << B)) : rt_in;
      end
    end

    if (k < SQRT_STAGES - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem[k] <= take ? (rem_in - trial[63:0]) : rem_in;
        end
      end
    end
  end

  assign root = rt[SQRT_STAGES-1];

endmodule

`default_nettype wire

// ===== rtl/gst_div.sv =====
// ----------------------------------------------------------------------------
// gst_div
// Pipelined restoring divider, 64 by 32 bit, quotient saturated to 47 bits.
// A zero divisor saturates.
// ----------------------------------------------------------------------------
`default_nettype none

module gst_div import gst_pkg::*; (
  input  logic                clk,
  input  logic                en,
  input  logic [63:0]         num,
  input  logic [31:0]         den,
  output logic [QUO_BITS-1:0] quo
);

  logic [63:0]         n0;
  logic [31:0]         d0;
  logic                ovf0;
  logic [63:0]         rem [QUO_BITS-1];
  logic [31:0]         dn  [QUO_BITS-1];
  logic                ov  [QUO_BITS];
  logic [QUO_BITS-1:0] q   [QUO_BITS];

  always_ff @(posedge clk) begin
    if (en) begin
      n0   <= num;
      d0   <= den;
      ovf0 <= {16'd0, num} >= ({48'd0, den} << QUO_BITS);
    end
  end

  for (genvar k = 0; k < QUO_BITS; k++) begin : g_stage
    localparam int B = QUO_BITS - 1 - k;
    logic [63:0]         rem_in;
    logic [31:0]         den_in;
    logic                ov_in;
    logic [QUO_BITS-1:0] q_in;
    logic [79:0]         trial;
    logic                take;

    if (k == 0) begin : g_first
      assign rem_in = n0;
      assign den_in = d0;
      assign ov_in  = ovf0;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem[k-1];
      assign den_in = dn[k-1];
      assign ov_in  = ov[k-1];
      assign q_in   = q[k-1];
    end

    assign trial = {48'd0, den_in} << B;
    assign take  = {16'd0, rem_in} >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        ov[k] <= ov_in;
        q[k]  <= take ? (q_in | ({{(QUO_BITS-1){1'b0}}, 1'b1} << B)) : q_in;
      end
    end

    if (k < QUO_BITS - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem[k] <= take ? (rem_in - trial[63:0]) : rem_in;
          dn[k]  <= den_in;
        end
      end
    end
  end

  assign quo = ov[QUO_BITS-1] ? '1 : q[QUO_BITS-1];

endmodule

`default_nettype wire

// ===== rtl/gst_front.sv =====
// ----------------------------------------------------------------------------
// gst_front
// Accepts items, forms the lengths r, v and a, and classifies termination.
// ----------------------------------------------------------------------------
`default_nettype none

module gst_front import gst_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  gst_item_if.sink items,
  output logic     push_valid,
  input  logic     push_ready,
  output q_entry_t push_data
);

  typedef struct packed {
    logic        mode;
    logic [15:0] steps;
    logic [31:0] vt;
    logic [62:0] sp;
  } side_t;

  logic [FRONT_STAGES-1:0] fv;
  logic                    en;

  logic [31:0] m0 [10];
  logic        mode0;
  logic [15:0] steps0;
  logic [63:0] sq1 [9];
  logic [62:0] sp1;
  logic [31:0] vt1;
  logic        mode1;
  logic [15:0] steps1;
  logic [63:0] sum2 [3];
  side_t       sb2;
  side_t       sbd [SQRT_STAGES];
  logic [31:0] rr, rv, ra;
  side_t       sb;
  reason_t     rsn;
  logic        cap, lt_in, gt_out;

  assign en          = !fv[FRONT_STAGES-1] || push_ready;
  assign items.ready = en;
  assign push_valid  = fv[FRONT_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= '0;
    end else if (en) begin
      fv <= {fv[FRONT_STAGES-2:0], items.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m0[0]  <= mag32(items.pos_x);
      m0[1]  <= mag32(items.pos_y);
      m0[2]  <= mag32(items.pos_z);
      m0[3]  <= mag32(items.vel_x);
      m0[4]  <= mag32(items.vel_y);
      m0[5]  <= mag32(items.vel_z);
      m0[6]  <= mag32(items.acc_x);
      m0[7]  <= mag32(items.acc_y);
      m0[8]  <= mag32(items.acc_z);
      m0[9]  <= mag32(items.vel_t);
      mode0  <= items.mode;
      steps0 <= items.step_count;

      for (int k = 0; k < 9; k++) begin
        sq1[k] <= m0[k] * m0[k];
      end
      sp1    <= cfg.stall_threshold * m0[9];
      vt1    <= m0[9];
      mode1  <= mode0;
      steps1 <= steps0;

      for (int k = 0; k < 3; k++) begin
        sum2[k] <= sq1[3*k] + sq1[3*k+1] + sq1[3*k+2];
      end
      sb2 <= '{mode: mode1, steps: steps1, vt: vt1, sp: sp1};

      sbd[0] <= sb2;
      for (int k = 1; k < SQRT_STAGES; k++) begin
        sbd[k] <= sbd[k-1];
      end

      push_data <= '{mode: sb.mode, reason: rsn, r: rr, v: rv, a: ra, vt: sb.vt};
    end
  end

  gst_isqrt u_len_r (.clk(clk), .en(en), .value(sum2[0]), .root(rr));
  gst_isqrt u_len_v (.clk(clk), .en(en), .value(sum2[1]), .root(rv));
  gst_isqrt u_len_a (.clk(clk), .en(en), .value(sum2[2]), .root(ra));

  assign sb     = sbd[SQRT_STAGES-1];
  // |v/vt| < threshold, cross-multiplied; vt zero gives a zero product
  assign cap    = {15'd0, rv, 16'd0} < sb.sp;
  assign lt_in  = rr < {1'b0, cfg.inner_limit};
  assign gt_out = rr > {1'b0, cfg.outer_limit};

  always_comb begin
    rsn = REASON_NONE;
    if (sb.mode) begin
      if (lt_in || gt_out) rsn = REASON_RANGE;
    end else if (cap) begin
      rsn = REASON_CAPTURED;
    end else if (sb.steps >= cfg.step_limit) begin
      rsn = REASON_STEPS;
    end else if (gt_out) begin
      rsn = REASON_ESCAPED;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/gst_queue.sv =====
// ----------------------------------------------------------------------------
// gst_queue
// Short FIFO between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module gst_queue import gst_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push_valid,
  output logic     push_ready,
  input  q_entry_t push_data,
  output logic     pop_valid,
  input  logic     pop_ready,
  output q_entry_t pop_data
);

  q_entry_t          mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr, rd;
  logic [QCNT_W-1:0] count;
  logic              push, pop;

  assign push_ready = count != QCNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem[rd];

  always_ff @(posedge clk) begin
    if (push) mem[wr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr    <= '0;
      rd    <= '0;
      count <= '0;
    end else begin
      if (push) wr <= wr + 1'b1;
      if (pop)  rd <= rd + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/gst_back.sv =====
// ----------------------------------------------------------------------------
// gst_back
// Forms the three step terms, the near-horizon factor and the final step.
// ----------------------------------------------------------------------------
`default_nettype none

module gst_back import gst_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  cfg_t           cfg,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  q_entry_t       pop_data,
  gst_result_if.source   results
);

  typedef struct packed {
    reason_t reason;
    logic    hz;
  } flag_t;

  typedef struct packed {
    logic [30:0] t1;
    logic [30:0] t3;
  } terms_t;

  logic [BACK_STAGES-1:0] bv;
  logic                   en;
  flag_t                  fl [BACK_STAGES-1];
  terms_t                 td [SQRT_STAGES];

  logic [62:0]         er, rtr;
  logic [30:0]         rc;
  logic [31:0]         v0, a0, vt0;
  logic [30:0]         eps;
  logic [QUO_BITS-1:0] q1, q2, q3, qf, q2c;
  logic [31:0]         root2, rootf;
  logic [30:0]         t2c, m_next, m_r;
  logic [16:0]         f_r;
  logic [47:0]         prod;
  logic [30:0]         out_dt;
  reason_t             out_reason;

  assign en        = !bv[BACK_STAGES-1] || results.ready;
  assign pop_ready = en;
  assign eps       = pop_data.mode ? cfg.observer_tolerance : cfg.ray_tolerance;

  always_ff @(posedge clk) begin
    if (rst) begin
      bv <= '0;
    end else if (en) begin
      bv <= {bv[BACK_STAGES-2:0], pop_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      er  <= eps * pop_data.r;
      rtr <= cfg.ray_tolerance * pop_data.r;
      rc  <= (pop_data.r < {1'b0, cfg.horizon_radius}) ? pop_data.r[30:0]
                                                       : cfg.horizon_radius;
      v0  <= pop_data.v;
      a0  <= pop_data.a;
      vt0 <= pop_data.vt;

      fl[0] <= '{reason: pop_data.reason, hz: cfg.horizon_radius == '0};
      for (int k = 1; k < BACK_STAGES - 1; k++) begin
        fl[k] <= fl[k-1];
      end

      td[0] <= '{t1: sat31(q1), t3: sat31(q3)};
      for (int k = 1; k < SQRT_STAGES; k++) begin
        td[k] <= td[k-1];
      end

      m_r <= m_next;
      f_r <= fl[BACK_STAGES-3].hz ? 17'h1_0000 : rootf[16:0];

      out_dt     <= prod[47] ? SAT_MAX : prod[46:16];
      out_reason <= fl[BACK_STAGES-2].reason;
    end
  end

  gst_div u_div_t1 (.clk(clk), .en(en), .num({1'b0, er}), .den(v0), .quo(q1));
  gst_div u_div_t2 (.clk(clk), .en(en), .num({er, 1'b0}), .den(a0), .quo(q2));
  gst_div u_div_t3 (.clk(clk), .en(en), .num({1'b0, rtr}), .den(vt0), .quo(q3));
  gst_div u_div_f  (.clk(clk), .en(en), .num({1'b0, rc, 32'd0}),
                    .den({1'b0, cfg.horizon_radius}), .quo(qf));

  // quotient for the acceleration term is capped at 2^46
  assign q2c = q2[QUO_BITS-1] ? {1'b1, {(QUO_BITS-1){1'b0}}} : q2;

  gst_isqrt u_sqrt_t2 (.clk(clk), .en(en), .value({1'b0, q2c, 16'd0}), .root(root2));
  gst_isqrt u_sqrt_f  (.clk(clk), .en(en), .value({17'd0, qf}), .root(rootf));

  assign t2c = root2[31] ? SAT_MAX : root2[30:0];

  always_comb begin
    m_next = td[SQRT_STAGES-1].t1;
    if (t2c < m_next) m_next = t2c;
    if (td[SQRT_STAGES-1].t3 < m_next) m_next = td[SQRT_STAGES-1].t3;
  end

  assign prod = m_r * f_r;

  assign results.valid      = bv[BACK_STAGES-1];
  assign results.step_size  = out_dt;
  assign results.finished   = out_reason != REASON_NONE;
  assign results.end_reason = out_reason;

endmodule

`default_nettype wire
